@@ src/rsakm_pkg.sv @@
// Shared types and codes for the RSA key generation and modular exponent unit.
// No dependencies.
`default_nettype none
package rsakm_pkg;

  typedef enum logic [1:0] {
    OP_GENERATE = 2'd0,
    OP_ENCRYPT  = 2'd1,
    OP_DECRYPT  = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_KEYS  = 2'd1,
    ST_GEN_FAIL = 2'd2,
    ST_UNUSED   = 2'd3
  } status_e;

  localparam logic REG_PRIME_P = 1'b0;
  localparam logic REG_PRIME_Q = 1'b1;

  localparam logic [15:0] PRIME_P_RESET = 16'd4001;
  localparam logic [15:0] PRIME_Q_RESET = 16'd4003;

  localparam int OUT_W = 96;

endpackage
`default_nettype wire

@@ src/rsa_keygen_modexp_unit.sv @@
// Top level of the RSA key generation and modular exponent unit.
// Depends on rsakm_pkg.
//
// Usage: a request on the slave stream carries the operation in tuser and the
// value in tdata. Generate forms n = p*q, picks e (smallest >= 2 coprime to
// phi) with a binary gcd, and d with extended Euclid on a shift-subtract
// divider. Encrypt and decrypt run square-and-multiply on a bit-serial modular
// multiplier: up to 64 multiplications plus one reduction. Generate runs the
// gcd search, then per Euclid step a check, a divide with the quotient times
// nt accumulated alongside, and an update.
// One request is worked at a time; tready is high only while the engine is
// idle, even while a finished result waits on the master side.
// Each request gives one result; if the receiver stalls, the result holds in
// the output register and the next request may still be taken.
// Reset restores the factors to 4001 and 4003 and clears the keys.
// The config channel is always ready; index 0 writes p, index 1 writes q.
`default_nettype none
module rsa_keygen_modexp_unit
  import rsakm_pkg::*;
#(
  parameter int PRIME_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,  // value
  input  wire logic [1:0]          s_axis_tuser,  // operation
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OUT_W-1:0]         m_axis_tdata,  // result, public_exponent, private_exponent
  output logic [1:0]               m_axis_tuser,  // status
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [0:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  localparam int FactW = (PRIME_BITS >= 16) ? 16 : PRIME_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_GEN, S_PHI, S_PHICHK, S_GCD, S_EMOD, S_EE_CHK, S_EE_DIV,
    S_EE_UPD, S_EE_FIN, S_RED, S_EXP_CHK, S_MUL_ACC, S_SQR, S_FINISH
  } state_e;

  state_e state_q;
  logic [15:0] p_q, q_q;
  logic [31:0] mod_q, pub_q, priv_q;
  logic        keys_q;
  logic [31:0] nn_q, phi_q, e_q, ga_q, gb_q;
  logic [31:0] r_q, nr_q;
  logic signed [33:0] t_q, nt_q, prod_q;
  logic [31:0] dv_rem_q, dv_quo_q, dv_den_q;
  logic [31:0] mm_a_q, mm_b_q, mm_acc_q;
  logic [31:0] ex_q, base_q, acc_q, res_q;
  logic [4:0]  cnt_q;
  logic [1:0]  st_q;
  logic        m_valid_q;
  logic [OUT_W-1:0] m_data_q;
  logic [1:0]  m_user_q;

  logic [15:0] pm, qm;
  assign pm = 16'(p_q[FactW-1:0]);
  assign qm = 16'(q_q[FactW-1:0]);

  // divider step
  logic [32:0] dv_sh, dv_sub;
  logic        dv_bit;
  assign dv_sh  = {dv_rem_q, dv_quo_q[31]};
  assign dv_sub = dv_sh - {1'b0, dv_den_q};
  assign dv_bit = (dv_sh >= {1'b0, dv_den_q});

  // modular multiplier step: acc = (2*acc + abit*b) mod n
  logic [33:0] mm_r, mm_m, mm_2m, mm_res34;
  logic [31:0] mm_res;
  always_comb begin
    mm_m  = {2'b0, mod_q};
    mm_2m = {1'b0, mod_q, 1'b0};
    mm_r  = {1'b0, mm_acc_q, 1'b0} + (mm_a_q[31] ? {2'b0, mm_b_q} : 34'd0);
    if (mm_r >= mm_2m) begin
      mm_res34 = mm_r - mm_2m;
    end else if (mm_r >= mm_m) begin
      mm_res34 = mm_r - mm_m;
    end else begin
      mm_res34 = mm_r;
    end
    mm_res = mm_res34[31:0];
  end

  logic signed [33:0] phi_s, d_t, d_fin;
  assign phi_s  = $signed({2'b0, phi_q});
  assign d_t    = t_q[33] ? t_q + phi_s : t_q;
  assign d_fin  = (d_t < 34'sd2) ? d_t + phi_s : d_t;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_q       <= PRIME_P_RESET;
      q_q       <= PRIME_Q_RESET;
      mod_q     <= '0;
      pub_q     <= '0;
      priv_q    <= '0;
      keys_q    <= 1'b0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_PRIME_P: p_q <= cfg_data_i;
          REG_PRIME_Q: q_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            res_q <= '0;
            st_q  <= ST_OK;
            unique case (op_e'(s_axis_tuser))
              OP_GENERATE: state_q <= S_GEN;
              OP_ENCRYPT, OP_DECRYPT: begin
                if (!keys_q || mod_q == '0) begin
                  st_q    <= ST_NO_KEYS;
                  state_q <= S_FINISH;
                end else begin
                  ex_q     <= (op_e'(s_axis_tuser) == OP_ENCRYPT) ? pub_q : priv_q;
                  mm_a_q   <= s_axis_tdata;
                  mm_b_q   <= 32'd1;
                  mm_acc_q <= '0;
                  cnt_q    <= '0;
                  state_q  <= S_RED;
                end
              end
              default: state_q <= S_FINISH;
            endcase
          end
        end
        S_GEN: begin
          if (pm < 16'd2 || qm < 16'd2) begin
            keys_q  <= 1'b0;
            mod_q   <= '0;
            pub_q   <= '0;
            priv_q  <= '0;
            st_q    <= ST_GEN_FAIL;
            state_q <= S_FINISH;
          end else begin
            nn_q    <= 32'(pm) * 32'(qm);
            state_q <= S_PHI;
          end
        end
        S_PHI: begin
          phi_q   <= 32'(pm - 16'd1) * 32'(qm - 16'd1);
          state_q <= S_PHICHK;
        end
        S_PHICHK: begin
          if (phi_q < 32'd2) begin
            keys_q  <= 1'b0;
            mod_q   <= '0;
            pub_q   <= '0;
            priv_q  <= '0;
            st_q    <= ST_GEN_FAIL;
            state_q <= S_FINISH;
          end else begin
            e_q     <= 32'd2;
            ga_q    <= 32'd2;
            gb_q    <= phi_q;
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          priority if (ga_q == '0 || gb_q == '0 || (!ga_q[0] && !gb_q[0])) begin
            if ((ga_q == '0 && gb_q == 32'd1) || (gb_q == '0 && ga_q == 32'd1)) begin
              dv_rem_q <= '0;
              dv_quo_q <= e_q;
              dv_den_q <= phi_q;
              cnt_q    <= '0;
              state_q  <= S_EMOD;
            end else begin
              e_q  <= e_q + 32'd1;
              ga_q <= e_q + 32'd1;
              gb_q <= phi_q;
            end
          end else if (!ga_q[0]) begin
            ga_q <= ga_q >> 1;
          end else if (!gb_q[0]) begin
            gb_q <= gb_q >> 1;
          end else if (ga_q >= gb_q) begin
            ga_q <= ga_q - gb_q;
          end else begin
            gb_q <= gb_q - ga_q;
          end
        end
        S_EMOD, S_EE_DIV: begin
          dv_rem_q <= dv_bit ? dv_sub[31:0] : dv_sh[31:0];
          dv_quo_q <= {dv_quo_q[30:0], dv_bit};
          cnt_q    <= cnt_q + 5'd1;
          // quotient bits arrive MSB first: accumulate quotient * nt
          if (state_q == S_EE_DIV) begin
            prod_q <= (prod_q <<< 1) + (dv_bit ? nt_q : 34'sd0);
          end
          if (cnt_q == 5'd31) begin
            if (state_q == S_EMOD) begin
              r_q     <= phi_q;
              nr_q    <= dv_bit ? dv_sub[31:0] : dv_sh[31:0];
              t_q     <= 34'sd0;
              nt_q    <= 34'sd1;
              state_q <= S_EE_CHK;
            end else begin
              state_q <= S_EE_UPD;
            end
          end
        end
        S_EE_CHK: begin
          if (nr_q == '0) begin
            state_q <= S_EE_FIN;
          end else begin
            dv_rem_q <= '0;
            dv_quo_q <= r_q;
            dv_den_q <= nr_q;
            prod_q   <= 34'sd0;
            cnt_q    <= '0;
            state_q  <= S_EE_DIV;
          end
        end
        S_EE_UPD: begin
          t_q     <= nt_q;
          nt_q    <= t_q - prod_q;
          r_q     <= nr_q;
          nr_q    <= dv_rem_q;
          state_q <= S_EE_CHK;
        end
        S_EE_FIN: begin
          mod_q   <= nn_q;
          pub_q   <= e_q;
          priv_q  <= d_fin[31:0];
          keys_q  <= 1'b1;
          res_q   <= nn_q;
          state_q <= S_FINISH;
        end
        S_RED, S_MUL_ACC, S_SQR: begin
          mm_acc_q <= mm_res;
          mm_a_q   <= {mm_a_q[30:0], 1'b0};
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            cnt_q    <= '0;
            mm_acc_q <= '0;
            unique case (state_q)
              S_RED: begin
                base_q  <= mm_res;
                acc_q   <= 32'd1;
                state_q <= S_EXP_CHK;
              end
              S_MUL_ACC: begin
                acc_q   <= mm_res;
                mm_a_q  <= base_q;
                mm_b_q  <= base_q;
                state_q <= S_SQR;
              end
              default: begin
                base_q  <= mm_res;
                ex_q    <= ex_q >> 1;
                state_q <= S_EXP_CHK;
              end
            endcase
          end
        end
        S_EXP_CHK: begin
          cnt_q    <= '0;
          mm_acc_q <= '0;
          if (ex_q == '0) begin
            res_q   <= acc_q;
            state_q <= S_FINISH;
          end else if (ex_q[0]) begin
            mm_a_q  <= acc_q;
            mm_b_q  <= base_q;
            state_q <= S_MUL_ACC;
          end else begin
            mm_a_q  <= base_q;
            mm_b_q  <= base_q;
            state_q <= S_SQR;
          end
        end
        S_FINISH: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {(keys_q ? priv_q : 32'd0), (keys_q ? pub_q : 32'd0), res_q};
            m_user_q  <= st_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/rsakm_checker.sv @@
// Port-level checks for rsa_keygen_modexp_unit, bound to the top level.
// Depends on rsakm_pkg.
`default_nettype none
module rsakm_checker
  import rsakm_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic [1:0]       m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_no_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_NO_KEYS |-> m_axis_tdata == '0)
    else $error("missing-key result not zero");

  a_gen_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_GEN_FAIL |-> m_axis_tdata == '0)
    else $error("failed generate not zero");

endmodule

bind rsa_keygen_modexp_unit rsakm_checker u_rsakm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
